@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL, included by rigid_point_kinematics.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rpk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpk_pkg;

  // One vector component or rotation entry.
  localparam int LaneW = 16;
  localparam int VecW = 3 * LaneW;

  // Fraction bits dropped after R*p (Q2.14 times Q8.8) and after a cross product.
  localparam int RotFrac = 14;
  localparam int CrossFrac = 8;

  // Exact sum of three 16x16 products, and the rounded offset r.
  localparam int DotSumW = 2 * LaneW + 2;
  localparam int RW = DotSumW - RotFrac;

  // Rounded cross product widths: w x r (and alpha x r), then w x (w x r).
  localparam int Cross1W = RW + LaneW + 1 - CrossFrac;
  localparam int Cross2W = Cross1W + LaneW + 1 - CrossFrac;

  // Common width of the final sums before saturation.
  localparam int SatW = Cross2W + 2;

  // Configuration register indexes.
  localparam int CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_POINT_X = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_POINT_Y = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_POINT_Z = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_GOAL_X  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_GOAL_Y  = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_GOAL_Z  = 3'd5;

  // Clamp a wide signed value to one signed 16-bit component.
  function automatic logic [LaneW-1:0] sat_lane(input logic signed [SatW-1:0] x);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(32767);
    lo = -hi - SatW'(1);
    if (x > hi) begin
      sat_lane = hi[LaneW-1:0];
    end else if (x < lo) begin
      sat_lane = lo[LaneW-1:0];
    end else begin
      sat_lane = x[LaneW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/rpk_dot_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One row of R times the body point, rounded to Q.8. Two register stages.
module rpk_dot_lane import rpk_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [VecW-1:0]          row_i,
  input  wire logic signed [LaneW-1:0]  p_i [3],
  output logic signed [RW-1:0]          r_o
);

  localparam logic signed [DotSumW-1:0] HalfLsb = DotSumW'(1) <<< (RotFrac - 1);

  logic signed [2*LaneW-1:0]  prod_q [3];
  logic signed [DotSumW-1:0]  sum_d;
  logic signed [RW-1:0]       r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= $signed(row_i[k*LaneW +: LaneW]) * p_i[k];
      end
    end
  end

  assign sum_d = DotSumW'(prod_q[0]) + DotSumW'(prod_q[1]) + DotSumW'(prod_q[2]) + HalfLsb;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= sum_d[DotSumW-1:RotFrac];
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

@@ sv/rpk_cross_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One component of u x b: ua*bb - ub*ba, rounded by CrossFrac bits.
// Two register stages: the products, then the rounded difference.
module rpk_cross_lane import rpk_pkg::*; #(
  parameter int BW = RW
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [LaneW-1:0]  ua_i,
  input  wire logic signed [LaneW-1:0]  ub_i,
  input  wire logic signed [BW-1:0]     ba_i,
  input  wire logic signed [BW-1:0]     bb_i,
  output logic signed [BW+LaneW-CrossFrac:0] c_o
);

  localparam int PW = LaneW + BW;
  localparam logic signed [PW:0] HalfLsb = (PW + 1)'(1) <<< (CrossFrac - 1);

  logic signed [PW-1:0] pa_q;
  logic signed [PW-1:0] pb_q;
  logic signed [PW:0]   diff_d;
  logic signed [BW+LaneW-CrossFrac:0] c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= ua_i * bb_i;
      pb_q <= ub_i * ba_i;
    end
  end

  assign diff_d = (PW + 1)'(pa_q) - (PW + 1)'(pb_q) + HalfLsb;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= diff_d[PW:CrossFrac];
    end
  end

  assign c_o = c_q;

endmodule

`default_nettype wire

@@ sv/rigid_point_kinematics.sv @@
// Throughput: one beat per cycle; the seven-stage pipeline advances whenever the
// output register is empty or its beat is taken, and holds as a whole otherwise.
// Reset (rst_ni low, asynchronous): all stage valid bits clear, and the body point
// and target registers return to zero. Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rigid_point_kinematics import rpk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // Configuration: body point and world target, signed Q8.8.
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [LaneW-1:0]     cfg_wdata_i,

  // Input beat: one body state.
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [VecW-1:0]      rot_row0_i,
  input  wire logic [VecW-1:0]      rot_row1_i,
  input  wire logic [VecW-1:0]      rot_row2_i,
  input  wire logic [VecW-1:0]      origin_i,
  input  wire logic [VecW-1:0]      lin_vel_i,
  input  wire logic [VecW-1:0]      ang_vel_i,
  input  wire logic [VecW-1:0]      lin_acc_i,
  input  wire logic [VecW-1:0]      ang_acc_i,

  // Output beat: point kinematics, each component saturated to 16 bits.
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [VecW-1:0]           point_pos_o,
  output logic [VecW-1:0]           point_vel_o,
  output logic [VecW-1:0]           point_acc_o,
  output logic [VecW-1:0]           pos_error_o
);

  // Pipeline map, stages numbered from the input:
  //   1, 2 : per-axis dot lanes form r = R*p.
  //   3, 4 : per-axis cross lanes form w x r and alpha x r.
  //   5, 6 : per-axis cross lanes form w x (w x r).
  //   7    : merge stage adds the terms, saturates, and is the output register.
  localparam int NumStages = 7;

  // The part of a body state that rides along the pipeline untouched.
  typedef struct packed {
    logic [VecW-1:0] origin;
    logic [VecW-1:0] lin_vel;
    logic [VecW-1:0] ang_vel;
    logic [VecW-1:0] lin_acc;
    logic [VecW-1:0] ang_acc;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to an index past the goal registers are
  // dropped.
  // ---------------------------------------------------------------------------
  logic signed [LaneW-1:0] point_q [3];
  logic signed [LaneW-1:0] goal_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        point_q[k] <= '0;
        goal_q[k]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_POINT_X: point_q[0] <= cfg_wdata_i;
        REG_POINT_Y: point_q[1] <= cfg_wdata_i;
        REG_POINT_Z: point_q[2] <= cfg_wdata_i;
        REG_GOAL_X:  goal_q[0]  <= cfg_wdata_i;
        REG_GOAL_Y:  goal_q[1]  <= cfg_wdata_i;
        REG_GOAL_Z:  goal_q[2]  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it stalls only when the
  // output register holds a beat that the consumer does not take.
  // ---------------------------------------------------------------------------
  logic                 en;
  logic                 in_accept;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;

  assign en         = !vld_q[NumStages-1] || out_ready_i;
  assign in_accept  = in_valid_i && en;
  assign in_ready_o = en;

  assign vld_d = en ? {vld_q[NumStages-2:0], in_accept} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Side data shift line; side_q[n] lines up with stage n+1.
  side_t side_q [NumStages-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{origin:  origin_i,
                     lin_vel: lin_vel_i,
                     ang_vel: ang_vel_i,
                     lin_acc: lin_acc_i,
                     ang_acc: ang_acc_i};
      for (int n = 1; n < NumStages - 1; n++) begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes. Each axis has its own dot lane and its own cross lanes; a cross
  // lane for axis i takes the other two axes of its operands.
  // ---------------------------------------------------------------------------
  logic [VecW-1:0]             rows [3];
  logic signed [RW-1:0]        r_s2 [3];
  logic signed [Cross1W-1:0]   wr_s4 [3];
  logic signed [Cross1W-1:0]   alr_s4 [3];
  logic signed [Cross2W-1:0]   wwr_s6 [3];

  assign rows[0] = rot_row0_i;
  assign rows[1] = rot_row1_i;
  assign rows[2] = rot_row2_i;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int Ia = (i + 1) % 3;
    localparam int Ib = (i + 2) % 3;

    rpk_dot_lane u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (rows[i]),
      .p_i   (point_q),
      .r_o   (r_s2[i])
    );

    rpk_cross_lane #(
      .BW (RW)
    ) u_wr (
      .clk_i (clk_i),
      .en_i  (en),
      .ua_i  ($signed(side_q[1].ang_vel[Ia*LaneW +: LaneW])),
      .ub_i  ($signed(side_q[1].ang_vel[Ib*LaneW +: LaneW])),
      .ba_i  (r_s2[Ia]),
      .bb_i  (r_s2[Ib]),
      .c_o   (wr_s4[i])
    );

    rpk_cross_lane #(
      .BW (RW)
    ) u_alr (
      .clk_i (clk_i),
      .en_i  (en),
      .ua_i  ($signed(side_q[1].ang_acc[Ia*LaneW +: LaneW])),
      .ub_i  ($signed(side_q[1].ang_acc[Ib*LaneW +: LaneW])),
      .ba_i  (r_s2[Ia]),
      .bb_i  (r_s2[Ib]),
      .c_o   (alr_s4[i])
    );

    rpk_cross_lane #(
      .BW (Cross1W)
    ) u_wwr (
      .clk_i (clk_i),
      .en_i  (en),
      .ua_i  ($signed(side_q[3].ang_vel[Ia*LaneW +: LaneW])),
      .ub_i  ($signed(side_q[3].ang_vel[Ib*LaneW +: LaneW])),
      .ba_i  (wr_s4[Ia]),
      .bb_i  (wr_s4[Ib]),
      .c_o   (wwr_s6[i])
    );
  end

  // Delay r from stage 2 and the first cross products from stage 4 so that
  // all terms meet at stage 6.
  logic signed [RW-1:0]      r_dly_q [4][3];
  logic signed [Cross1W-1:0] wr_dly_q [2][3];
  logic signed [Cross1W-1:0] alr_dly_q [2][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_dly_q[0]   <= r_s2;
      r_dly_q[1]   <= r_dly_q[0];
      r_dly_q[2]   <= r_dly_q[1];
      r_dly_q[3]   <= r_dly_q[2];
      wr_dly_q[0]  <= wr_s4;
      wr_dly_q[1]  <= wr_dly_q[0];
      alr_dly_q[0] <= alr_s4;
      alr_dly_q[1] <= alr_dly_q[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Merge stage. The error uses the unsaturated position, so a clamped
  // position never feeds the error.
  // ---------------------------------------------------------------------------
  logic [VecW-1:0] pos_d, vel_d, acc_d, err_d;
  logic [VecW-1:0] pos_q, vel_q, acc_q, err_q;

  always_comb begin
    logic signed [SatW-1:0] pos_w;
    logic signed [SatW-1:0] vel_w;
    logic signed [SatW-1:0] acc_w;
    logic signed [SatW-1:0] err_w;
    pos_d = '0;
    vel_d = '0;
    acc_d = '0;
    err_d = '0;
    for (int k = 0; k < 3; k++) begin
      pos_w = SatW'($signed(side_q[5].origin[k*LaneW +: LaneW])) + SatW'(r_dly_q[3][k]);
      vel_w = SatW'($signed(side_q[5].lin_vel[k*LaneW +: LaneW])) + SatW'(wr_dly_q[1][k]);
      acc_w = SatW'($signed(side_q[5].lin_acc[k*LaneW +: LaneW])) + SatW'(alr_dly_q[1][k])
            + SatW'(wwr_s6[k]);
      err_w = pos_w - SatW'(goal_q[k]);
      pos_d[k*LaneW +: LaneW] = sat_lane(pos_w);
      vel_d[k*LaneW +: LaneW] = sat_lane(vel_w);
      acc_d[k*LaneW +: LaneW] = sat_lane(acc_w);
      err_d[k*LaneW +: LaneW] = sat_lane(err_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q <= pos_d;
      vel_q <= vel_d;
      acc_q <= acc_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign point_pos_o = pos_q;
  assign point_vel_o = vel_q;
  assign point_acc_o = acc_q;
  assign pos_error_o = err_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en, $stable(vld_q), "stage valids moved during stall")
  `ASSERT_NEXT(a_shift, clk_i, rst_ni, en, vld_q[NumStages-1:1] == $past(vld_q[NumStages-2:0]), "stage valids did not shift")
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_accept, vld_q[0], "accepted beat missing from first stage")
  `ASSERT_IMPL(a_out_source, clk_i, rst_ni, $rose(out_valid_o), $past(vld_q[NumStages-2]), "result beat without a predecessor")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// The block is a seven-stage pipeline. It computes the position, velocity and
// acceleration of one fixed body point, and its error against a target.
// This bench feeds it body-state beats, predicts every result beat from the
// same fixed-point rules, and compares the two in order of arrival.

module testbench;
  import rpk_pkg::*;

  // The pipeline depth given at the head of the block, used for pauses.
  localparam int PipeDepth = 7;
  // The watchdog ends the run after this many cycles without any beat.
  localparam int StallLimit = 1000;
  // Random body states sent under each register setting.
  localparam int RandomPerPhase = 145;
  // The receiver holds off for this many cycles during the pressure phase.
  localparam int HoldCycles = 80;

  // Register indexes past the last register. The block must ignore writes to them.
  localparam logic [CfgAddrW-1:0] REG_SPARE_A = CfgAddrW'(6);
  localparam logic [CfgAddrW-1:0] REG_SPARE_B = CfgAddrW'(7);

  typedef struct packed {
    logic [VecW-1:0] rot_row0;
    logic [VecW-1:0] rot_row1;
    logic [VecW-1:0] rot_row2;
    logic [VecW-1:0] origin;
    logic [VecW-1:0] lin_vel;
    logic [VecW-1:0] ang_vel;
    logic [VecW-1:0] lin_acc;
    logic [VecW-1:0] ang_acc;
  } body_state_t;

  typedef struct packed {
    logic [VecW-1:0] point_pos;
    logic [VecW-1:0] point_vel;
    logic [VecW-1:0] point_acc;
    logic [VecW-1:0] pos_error;
  } point_kin_t;

  // The scoreboard keeps its own copy of the body point and the target. For
  // every accepted body state it queues the kinematics that the block must
  // return.
  class kinematics_scoreboard;
    logic signed [LaneW-1:0] point [3];
    logic signed [LaneW-1:0] goal [3];
    point_kin_t expected_kin [$];
    int failures;
    int results_seen;

    function new();
      int k;
      for (k = 0; k < 3; k++) begin
        point[k] = '0;
        goal[k] = '0;
      end
      failures = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CfgAddrW-1:0] idx, logic [LaneW-1:0] value);
      case (idx)
        REG_POINT_X: point[0] = value;
        REG_POINT_Y: point[1] = value;
        REG_POINT_Z: point[2] = value;
        REG_GOAL_X:  goal[0] = value;
        REG_GOAL_Y:  goal[1] = value;
        REG_GOAL_Z:  goal[2] = value;
        default: ;
      endcase
    endfunction

    function int pending_count();
      return expected_kin.size();
    endfunction

    function longint lane_of(logic [VecW-1:0] word, int k);
      return longint'($signed(word[LaneW*k +: LaneW]));
    endfunction

    // Round to nearest by adding half an LSB and then flooring.
    function longint rounded_shift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function logic [LaneW-1:0] clamp16(longint x);
      if (x > 32767) return 16'h7FFF;
      if (x < -32768) return 16'h8000;
      return x[LaneW-1:0];
    endfunction

    // The first input is a Q8.8 vector and the second a wide Q.8 vector.
    // The exact Q.16 product is rounded back to Q.8.
    function void cross_round(input longint u [3], input longint b [3],
                              output longint c [3]);
      c[0] = rounded_shift(u[1] * b[2] - u[2] * b[1], CrossFrac);
      c[1] = rounded_shift(u[2] * b[0] - u[0] * b[2], CrossFrac);
      c[2] = rounded_shift(u[0] * b[1] - u[1] * b[0], CrossFrac);
    endfunction

    function void note_body_state(body_state_t s);
      logic [VecW-1:0] rows [3];
      longint t [3];
      longint v [3];
      longint w [3];
      longint a [3];
      longint al [3];
      longint r [3];
      longint wr [3];
      longint alr [3];
      longint wwr [3];
      longint dot;
      longint pos;
      point_kin_t kin;
      int i;
      int j;
      rows[0] = s.rot_row0;
      rows[1] = s.rot_row1;
      rows[2] = s.rot_row2;
      for (i = 0; i < 3; i++) begin
        t[i] = lane_of(s.origin, i);
        v[i] = lane_of(s.lin_vel, i);
        w[i] = lane_of(s.ang_vel, i);
        a[i] = lane_of(s.lin_acc, i);
        al[i] = lane_of(s.ang_acc, i);
        // The Q2.14 by Q8.8 dot product is exact, and is then rounded once to Q.8.
        dot = 0;
        for (j = 0; j < 3; j++) begin
          dot += lane_of(rows[i], j) * longint'(point[j]);
        end
        r[i] = rounded_shift(dot, RotFrac);
      end
      cross_round(w, r, wr);
      cross_round(al, r, alr);
      // The double cross product is built on the already rounded w x r.
      cross_round(w, wr, wwr);
      for (i = 0; i < 3; i++) begin
        pos = t[i] + r[i];
        kin.point_pos[LaneW*i +: LaneW] = clamp16(pos);
        kin.point_vel[LaneW*i +: LaneW] = clamp16(v[i] + wr[i]);
        kin.point_acc[LaneW*i +: LaneW] = clamp16(a[i] + alr[i] + wwr[i]);
        // The error is taken from the unclamped position.
        kin.pos_error[LaneW*i +: LaneW] = clamp16(pos - longint'(goal[i]));
      end
      expected_kin.push_back(kin);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void compare_field(string name, logic [VecW-1:0] want,
                                logic [VecW-1:0] got);
      if (got !== want) begin
        flag($sformatf("result %0d %s expected %h got %h", results_seen, name, want, got));
      end
    endfunction

    function void check_point_result(point_kin_t got);
      point_kin_t want;
      results_seen++;
      if (expected_kin.size() == 0) begin
        flag($sformatf("result %0d arrived with none expected (pos %h)",
                       results_seen, got.point_pos));
        return;
      end
      want = expected_kin.pop_front();
      compare_field("point_pos", want.point_pos, got.point_pos);
      compare_field("point_vel", want.point_vel, got.point_vel);
      compare_field("point_acc", want.point_acc, got.point_acc);
      compare_field("pos_error", want.pos_error, got.pos_error);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [LaneW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [VecW-1:0] rot_row0_i;
  logic [VecW-1:0] rot_row1_i;
  logic [VecW-1:0] rot_row2_i;
  logic [VecW-1:0] origin_i;
  logic [VecW-1:0] lin_vel_i;
  logic [VecW-1:0] ang_vel_i;
  logic [VecW-1:0] lin_acc_i;
  logic [VecW-1:0] ang_acc_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [VecW-1:0] point_pos_o;
  logic [VecW-1:0] point_vel_o;
  logic [VecW-1:0] point_acc_o;
  logic [VecW-1:0] pos_error_o;

  kinematics_scoreboard board;
  // When set, neither side idles. This gives one long stretch at full rate.
  bit steady;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request;

  rigid_point_kinematics dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rot_row0_i  (rot_row0_i),
    .rot_row1_i  (rot_row1_i),
    .rot_row2_i  (rot_row2_i),
    .origin_i    (origin_i),
    .lin_vel_i   (lin_vel_i),
    .ang_vel_i   (ang_vel_i),
    .lin_acc_i   (lin_acc_i),
    .ang_acc_i   (ang_acc_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .point_pos_o (point_pos_o),
    .point_vel_o (point_vel_o),
    .point_acc_o (point_acc_o),
    .pos_error_o (pos_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A random component. It is an extreme value now and then, often fully
  // random, and otherwise drawn at a random scale, so that some results
  // clamp and others stay in range.
  function automatic logic [LaneW-1:0] rand_lane();
    int unsigned pick;
    int unsigned scale;
    logic [LaneW-1:0] mag;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (pick < 40) return LaneW'($urandom);
    scale = $urandom_range(1, 15);
    mag = LaneW'($urandom_range(0, (1 << scale) - 1));
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic int rand_coord();
    return int'($signed(rand_lane()));
  endfunction

  function automatic logic [VecW-1:0] make_vec(int x, int y, int z);
    return {LaneW'(z), LaneW'(y), LaneW'(x)};
  endfunction

  function automatic body_state_t make_body(
      logic [VecW-1:0] r0, logic [VecW-1:0] r1, logic [VecW-1:0] r2,
      logic [VecW-1:0] t, logic [VecW-1:0] v, logic [VecW-1:0] w,
      logic [VecW-1:0] a, logic [VecW-1:0] al);
    body_state_t s;
    s.rot_row0 = r0;
    s.rot_row1 = r1;
    s.rot_row2 = r2;
    s.origin = t;
    s.lin_vel = v;
    s.ang_vel = w;
    s.lin_acc = a;
    s.ang_acc = al;
    return s;
  endfunction

  function automatic body_state_t uniform_body(logic [LaneW-1:0] x);
    logic [VecW-1:0] vec;
    vec = {x, x, x};
    return make_body(vec, vec, vec, vec, vec, vec, vec, vec);
  endfunction

  // About a quarter of the random states carry an exact rotation. That is a
  // signed permutation of unit Q2.14 entries. The rest have random rows.
  function automatic body_state_t random_body();
    body_state_t s;
    logic [VecW-1:0] rows [3];
    int cols [3];
    int i;
    if ($urandom_range(0, 99) < 25) begin
      cols[0] = $urandom_range(0, 2);
      cols[1] = (cols[0] + 1 + $urandom_range(0, 1)) % 3;
      cols[2] = 3 - cols[0] - cols[1];
      for (i = 0; i < 3; i++) begin
        rows[i] = '0;
        rows[i][LaneW*cols[i] +: LaneW] = ($urandom_range(0, 1) != 0) ? 16'hC000 : 16'h4000;
      end
    end else begin
      for (i = 0; i < 3; i++) rows[i] = {rand_lane(), rand_lane(), rand_lane()};
    end
    s = make_body(rows[0], rows[1], rows[2],
                  {rand_lane(), rand_lane(), rand_lane()},
                  {rand_lane(), rand_lane(), rand_lane()},
                  {rand_lane(), rand_lane(), rand_lane()},
                  {rand_lane(), rand_lane(), rand_lane()},
                  {rand_lane(), rand_lane(), rand_lane()});
    return s;
  endfunction

  // Offer one body state and return at the edge where it is taken. Valid is
  // lowered only when an idle gap comes first. A back-to-back beat keeps it high.
  task automatic send_body(input body_state_t s);
    int gap;
    gap = 0;
    while (!steady && gap < 30 && $urandom_range(0, 99) < 34) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rot_row0_i <= s.rot_row0;
    rot_row1_i <= s.rot_row1;
    rot_row2_i <= s.rot_row2;
    origin_i <= s.origin;
    lin_vel_i <= s.lin_vel;
    ang_vel_i <= s.ang_vel;
    lin_acc_i <= s.lin_acc;
    ang_acc_i <= s.ang_acc;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_body_state(s);
  endtask

  // Stop offering, wait until every expected beat has come back, then let the
  // pipeline run empty before the registers are touched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (2 * PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= LaneW'(value);
    @(posedge clk_i);
    board.set_register(idx, LaneW'(value));
  endtask

  // Write all six registers. Then write one index past the end, which must
  // leave every register as it was.
  task automatic apply_setting(input int px, input int py, input int pz,
                               input int gx, input int gy, input int gz);
    write_register(REG_POINT_X, px);
    write_register(REG_POINT_Y, py);
    write_register(REG_POINT_Z, pz);
    write_register(REG_GOAL_X, gx);
    write_register(REG_GOAL_Y, gy);
    write_register(REG_GOAL_Z, gz);
    write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                   int'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  // Result side. The beat is checked at the edge where it is taken. Then
  // ready is chosen for the next cycle. A requested hold-off keeps ready low
  // while its countdown runs, so the pipeline fills and stalls its input.
  initial begin : result_sink
    point_kin_t got;
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        got.point_pos = point_pos_o;
        got.point_vel = point_vel_o;
        got.point_acc = point_acc_o;
        got.pos_error = pos_error_o;
        board.check_point_result(got);
      end
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // The watchdog counts cycles in which neither side moves a beat.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles", StallLimit);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [VecW-1:0] e0;
    logic [VecW-1:0] e1;
    logic [VecW-1:0] e2;
    logic [VecW-1:0] zv;
    logic [VecW-1:0] hi;
    logic [VecW-1:0] lo;
    int phase;
    int n;
    board = new();
    steady = 1'b0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_POINT_X;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    rot_row0_i = '0;
    rot_row1_i = '0;
    rot_row2_i = '0;
    origin_i = '0;
    lin_vel_i = '0;
    ang_vel_i = '0;
    lin_acc_i = '0;
    ang_acc_i = '0;
    e0 = make_vec(16384, 0, 0);
    e1 = make_vec(0, 16384, 0);
    e2 = make_vec(0, 0, 16384);
    zv = '0;
    hi = make_vec(32767, 32767, 32767);
    lo = make_vec(-32768, -32768, -32768);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the point and the target at their reset value of zero, the offset
    // vanishes and the inputs pass straight through.
    send_body(uniform_body(16'h0000));
    send_body(uniform_body(16'h7FFF));
    send_body(uniform_body(16'h8000));
    send_body(uniform_body(16'hFFFF));
    for (n = 0; n < 40; n++) send_body(random_body());

    for (phase = 0; phase < 8; phase++) begin
      settle();
      steady = (phase == 5);
      case (phase)
        0: apply_setting(256, -512, 128, 2560, -768, 0);
        1: apply_setting(32767, 32767, 32767, -32768, -32768, -32768);
        2: apply_setting(-32768, -32768, -32768, 32767, 32767, 32767);
        3: apply_setting(32767, -32768, 0, 0, 32767, -32768);
        default: apply_setting(rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord());
      endcase

      if (phase == 0) begin
        // An identity rotation gives the offset equal to the point.
        send_body(make_body(e0, e1, e2, zv, zv, zv, zv, zv));
        // Some position components clamp, while the error is taken from the unclamped
        // sum and stays in range for some of them.
        send_body(make_body(e0, e1, e2, hi, zv, zv, zv, zv));
        send_body(make_body(e0, e1, e2, lo, zv, zv, zv, zv));
        // A quarter turn about z, spinning about z.
        send_body(make_body(make_vec(0, -16384, 0), make_vec(16384, 0, 0), e2,
                            make_vec(256, 0, 0), make_vec(0, 128, 0), make_vec(0, 0, 256),
                            make_vec(64, 0, 0), make_vec(0, 0, -128)));
        send_body(make_body(make_vec(-16384, 0, 0), make_vec(0, -16384, 0),
                            make_vec(0, 0, -16384), zv, zv, make_vec(256, 256, 256),
                            zv, make_vec(-256, 0, 256)));
        // Rotations that are far from orthonormal are used as given.
        send_body(make_body(hi, hi, hi, zv, zv, hi, zv, hi));
        send_body(make_body(lo, lo, lo, zv, zv, lo, zv, lo));
        send_body(make_body(zv, zv, zv, hi, hi, zv, hi, zv));
        send_body(make_body(zv, zv, zv, lo, lo, zv, lo, zv));
        send_body(make_body(e0, e1, e2, zv, zv, hi, zv, lo));
        send_body(make_body(e0, e1, e2, zv, zv, make_vec(256, 0, 0), zv,
                            make_vec(0, 256, 0)));
        // These entries put the offset exactly on a half LSB, so the
        // rounding ties are exercised.
        send_body(make_body(make_vec(32, 0, 0), make_vec(-32, 0, 0), make_vec(0, 16, 0),
                            zv, zv, make_vec(1, 1, 1), zv, make_vec(-1, -1, -1)));
        send_body(uniform_body(16'hFFFF));
        send_body(uniform_body(16'h7FFF));
        send_body(uniform_body(16'h8000));
        send_body(uniform_body(16'hAAAA));
        send_body(uniform_body(16'h5555));
        send_body(make_body(e0, e1, e2, make_vec(0, 0, 32767), hi, hi, lo, hi));
      end

      for (n = 0; n < RandomPerPhase; n++) begin
        // Partway through this phase the receiver holds off while beats keep
        // coming, so the pipeline fills and stalls its input.
        if (phase == 3 && n == 30) hold_request = 1'b1;
        send_body(random_body());
      end
    end

    steady = 1'b0;
    settle();
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/rpk_pkg.sv
sv/rpk_dot_lane.sv
sv/rpk_cross_lane.sv
sv/rigid_point_kinematics.sv
verif/testbench.sv
